// ===== rtl/vt52_pkg.sv =====
// Shared types, codes and helpers for the VT52 escape parser.
package vt52_pkg;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int OP_W    = 4;
  localparam int ROW_W   = 7;
  localparam int COL_W   = 8;
  localparam int ATTR_W  = 5;
  localparam int COLOR_W = 3;
  localparam int FLAG_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Screen limits
  localparam logic [COL_W-1:0] MaxCols  = 8'd160;
  localparam logic [ROW_W-1:0] MaxLines = 7'd96;

  // Register reset values
  localparam logic [COL_W-1:0]   RstCols  = 8'd80;
  localparam logic [ROW_W-1:0]   RstLines = 7'd24;
  localparam logic [COLOR_W-1:0] RstFg    = 3'd7;
  localparam logic [COLOR_W-1:0] RstBg    = 3'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COLS   = 2'd0,
    CFG_NUM_LINES  = 2'd1,
    CFG_DEFAULT_FG = 2'd2,
    CFG_DEFAULT_BG = 2'd3
  } cfg_idx_t;

  // Screen command codes
  typedef enum logic [OP_W-1:0] {
    OP_NONE        = 4'd0,
    OP_PRINT       = 4'd1,
    OP_MOVE        = 4'd2,
    OP_SCROLL_UP   = 4'd3,
    OP_SCROLL_DOWN = 4'd4,
    OP_CLEAR_HOME  = 4'd5,
    OP_CLR_EOS     = 4'd6,
    OP_CLR_EOL     = 4'd7,
    OP_INS_LINE    = 4'd8,
    OP_DEL_LINE    = 4'd9,
    OP_INS_BLANK   = 4'd10,
    OP_DEL_CHAR    = 4'd11,
    OP_BEEP        = 4'd12,
    OP_REPLY       = 4'd13
  } op_t;

  // Parser states, one-hot
  typedef enum logic [5:0] {
    PS_NORMAL = 6'b000001,
    PS_ESC    = 6'b000010,
    PS_ESCY   = 6'b000100,
    PS_ESCYL  = 6'b001000,
    PS_ESCS   = 6'b010000,
    PS_ESCT   = 6'b100000
  } pstate_t;

  // Control bytes
  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_CTRL_MAX = 8'h1f;
  localparam logic [7:0] CH_DEL      = 8'h7f;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_SEVEN    = 8'h37;
  localparam logic [7:0] CH_EQUAL    = 8'h3d;

  // Escape letters
  localparam logic [7:0] ESC_KP_OFF    = 8'h29;
  localparam logic [7:0] ESC_KP_ON     = 8'h3d;
  localparam logic [7:0] ESC_UP        = 8'h41;
  localparam logic [7:0] ESC_DOWN      = 8'h42;
  localparam logic [7:0] ESC_RIGHT     = 8'h43;
  localparam logic [7:0] ESC_LEFT      = 8'h44;
  localparam logic [7:0] ESC_CLR_HOME  = 8'h45;
  localparam logic [7:0] ESC_GFX_ON    = 8'h46;
  localparam logic [7:0] ESC_GFX_OFF   = 8'h47;
  localparam logic [7:0] ESC_HOME      = 8'h48;
  localparam logic [7:0] ESC_REV_LF    = 8'h49;
  localparam logic [7:0] ESC_CLR_EOS   = 8'h4a;
  localparam logic [7:0] ESC_CLR_EOL   = 8'h4b;
  localparam logic [7:0] ESC_INS_LINE  = 8'h4c;
  localparam logic [7:0] ESC_DEL_LINE  = 8'h4d;
  localparam logic [7:0] ESC_INS_BLANK = 8'h4e;
  localparam logic [7:0] ESC_DEL_CHAR  = 8'h4f;
  localparam logic [7:0] ESC_SET_BG    = 8'h53;
  localparam logic [7:0] ESC_SET_FG    = 8'h54;
  localparam logic [7:0] ESC_ADDR      = 8'h59;
  localparam logic [7:0] ESC_IDENT     = 8'h5a;
  localparam logic [7:0] ESC_HOLD_ON   = 8'h5b;
  localparam logic [7:0] ESC_HOLD_OFF  = 8'h5c;
  localparam logic [7:0] ESC_CUR_HIDE  = 8'h61;
  localparam logic [7:0] ESC_CUR_SHOW  = 8'h62;
  localparam logic [7:0] ESC_ALTCS_ON  = 8'h63;
  localparam logic [7:0] ESC_ALTCS_OFF = 8'h64;
  localparam logic [7:0] ESC_BOLD_ON   = 8'h65;
  localparam logic [7:0] ESC_BOLD_OFF  = 8'h66;
  localparam logic [7:0] ESC_UL_ON     = 8'h67;
  localparam logic [7:0] ESC_UL_OFF    = 8'h68;
  localparam logic [7:0] ESC_REV_ON    = 8'h69;
  localparam logic [7:0] ESC_REV_OFF   = 8'h6a;
  localparam logic [7:0] ESC_BLINK_ON  = 8'h6b;
  localparam logic [7:0] ESC_BLINK_OFF = 8'h6c;
  localparam logic [7:0] ESC_ATTR_RST  = 8'h6d;
  localparam logic [7:0] ESC_ALTKEY_ON = 8'h6e;
  localparam logic [7:0] ESC_ALTKEY_OFF = 8'h6f;
  localparam logic [7:0] ESC_SO_ON     = 8'h70;
  localparam logic [7:0] ESC_SO_OFF    = 8'h71;

  // Identify reply bytes
  localparam logic [7:0] REPLY_0 = 8'h1b;
  localparam logic [7:0] REPLY_1 = 8'h2f;
  localparam logic [7:0] REPLY_2 = 8'h4b;

  // Attribute bit positions
  localparam int ATTR_STANDOUT  = 0;
  localparam int ATTR_ULINE     = 1;
  localparam int ATTR_BLINK     = 2;
  localparam int ATTR_INVERSE   = 3;
  localparam int ATTR_BOLD      = 4;

  // Mode flag bit positions
  localparam int F_GRAPHICS = 0;
  localparam int F_ALTCS    = 1;
  localparam int F_ALTKEYS  = 2;
  localparam int F_KEYPAD   = 3;
  localparam int F_HOLD     = 4;
  localparam int F_CURHIDE  = 5;

  // Clamp a column count into 1..MaxCols
  function automatic logic [COL_W-1:0] eff_cols(input logic [COL_W-1:0] v);
    if (v == '0) return 8'd1;
    if (v > MaxCols) return MaxCols;
    return v;
  endfunction

  // Clamp a line count into 1..MaxLines
  function automatic logic [ROW_W-1:0] eff_lines(input logic [ROW_W-1:0] v);
    if (v == '0) return 7'd1;
    if (v > MaxLines) return MaxLines;
    return v;
  endfunction

  // Color select: a digit 0 to 7 picks a color, '=' the default, else keep
  function automatic logic [COLOR_W-1:0] pick_color(input logic [7:0] c,
                                                    input logic [COLOR_W-1:0] cur,
                                                    input logic [COLOR_W-1:0] def);
    if (c >= CH_ZERO && c <= CH_SEVEN) return c[COLOR_W-1:0];
    if (c == CH_EQUAL) return def;
    return cur;
  endfunction

endpackage

// ===== rtl/vt52_if.sv =====
// Valid/ready channel interfaces for terminal bytes and screen commands.
interface vt52_char_if import vt52_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface vt52_cmd_if import vt52_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [CHAR_W-1:0]  char_code;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [ATTR_W-1:0]  attributes;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [FLAG_W-1:0]  mode_flags;
  logic               last;

  modport source (output valid, output op, output char_code, output row, output col,
                  output attributes, output fg_color, output bg_color,
                  output mode_flags, output last, input ready);
  modport sink   (input valid, input op, input char_code, input row, input col,
                  input attributes, input fg_color, input bg_color,
                  input mode_flags, input last, output ready);
endinterface

// ===== rtl/vt52_escape_parser.sv =====
// VT52 control and escape parser: byte in, screen command out.
//
// Each byte written to the terminal is decoded against the parser state and
// lands in an output register as one screen command; one byte per clock is
// sustained as long as the consumer takes commands. ESC Z places the three
// identify reply bytes in the output register one after another, so it holds
// the output for three transactions and the byte input waits while the first
// and second reply bytes are shown; the next byte can be taken in the cycle
// the third goes out. The configuration port may be written only while no
// command is pending; a write of the screen size pulls the cursor inside.
module vt52_escape_parser import vt52_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  vt52_char_if.sink             chars,
  vt52_cmd_if.source            cmds
);

  // Configuration registers
  logic [COL_W-1:0]   num_cols;
  logic [ROW_W-1:0]   num_lines;
  logic [COLOR_W-1:0] default_fg;
  logic [COLOR_W-1:0] default_bg;

  // Parser state
  pstate_t            pstate;
  logic [7:0]         pending_row;
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_col;
  logic [ATTR_W-1:0]  attr_bits;
  logic [COLOR_W-1:0] fg_now;
  logic [COLOR_W-1:0] bg_now;
  logic [FLAG_W-1:0]  flag_bits;

  // Output register and reply sequencing
  logic       out_valid;
  logic [1:0] reply_left;

  // Next-state values
  pstate_t            pstate_next;
  logic [7:0]         pending_row_next;
  logic [ROW_W-1:0]   cursor_row_next;
  logic [COL_W-1:0]   cursor_col_next;
  logic [ATTR_W-1:0]  attr_bits_next;
  logic [COLOR_W-1:0] fg_now_next;
  logic [COLOR_W-1:0] bg_now_next;
  logic [FLAG_W-1:0]  flag_bits_next;
  op_t                op_sel;
  logic [CHAR_W-1:0]  char_sel;
  logic [ROW_W-1:0]   row_sel;
  logic [COL_W-1:0]   col_sel;

  // Working values
  logic [COL_W-1:0] cols;
  logic [ROW_W-1:0] lines;
  logic [7:0]       c;
  logic [8:0]       tab_stop;
  logic [7:0]       addr_row;
  logic [COL_W-1:0] addr_col;
  logic             in_fire;
  logic             out_fire;

  // Clamp values for a configuration write
  logic [COL_W-1:0] cfg_cols;
  logic [ROW_W-1:0] cfg_lines;

  assign cols     = eff_cols(num_cols);
  assign lines    = eff_lines(num_lines);
  assign c        = chars.char_in;
  assign out_fire = out_valid && cmds.ready;

  // Take a byte when no reply is pending and the output slot frees up
  assign chars.ready = (reply_left == 2'd0) && (!out_valid || cmds.ready);
  assign in_fire     = chars.valid && chars.ready;

  // Decode one byte against the current state
  always_comb begin
    pstate_next      = pstate;
    pending_row_next = pending_row;
    cursor_row_next  = cursor_row;
    cursor_col_next  = cursor_col;
    attr_bits_next   = attr_bits;
    fg_now_next      = fg_now;
    bg_now_next      = bg_now;
    flag_bits_next   = flag_bits;
    op_sel           = OP_NONE;
    char_sel         = '0;
    row_sel          = '0;
    col_sel          = '0;

    tab_stop = {({1'b0, cursor_col[7:3]} + 6'd1), 3'b000};
    if (tab_stop >= {1'b0, cols}) tab_stop = {1'b0, cursor_col} + 9'd1;

    addr_row = (pending_row >= {1'b0, lines}) ? {1'b0, lines - 7'd1} : pending_row;
    addr_col = c - CH_SPACE;
    if (addr_col >= cols) addr_col = cursor_col;

    if (c <= CH_CTRL_MAX) begin
      // Control bytes act at once; only ESC touches the parse state
      case (c)
        CH_BEL: op_sel = OP_BEEP;
        CH_BS: begin
          if (cursor_col != '0) begin
            cursor_col_next = cursor_col - 8'd1;
            op_sel = OP_MOVE;
          end
        end
        CH_TAB: begin
          if (tab_stop < {1'b0, cols}) begin
            cursor_col_next = tab_stop[COL_W-1:0];
            op_sel = OP_MOVE;
          end
        end
        CH_LF: begin
          if ({1'b0, cursor_row} + 8'd1 < {1'b0, lines}) begin
            cursor_row_next = cursor_row + 7'd1;
            op_sel = OP_MOVE;
          end else begin
            op_sel = OP_SCROLL_UP;
          end
        end
        CH_CR: begin
          if (cursor_col != '0) begin
            cursor_col_next = '0;
            op_sel = OP_MOVE;
          end
        end
        CH_ESC: pstate_next = PS_ESC;
        default: ;
      endcase
    end else if (c != CH_DEL) begin
      unique case (pstate)
        PS_NORMAL: begin
          // Print at the cursor, advance unless at the last column
          op_sel   = OP_PRINT;
          char_sel = c;
          if ({1'b0, cursor_col} + 9'd1 < {1'b0, cols}) cursor_col_next = cursor_col + 8'd1;
        end
        PS_ESC: begin
          pstate_next = PS_NORMAL;
          case (c)
            ESC_KP_OFF: flag_bits_next[F_KEYPAD] = 1'b0;
            ESC_KP_ON:  flag_bits_next[F_KEYPAD] = 1'b1;
            ESC_UP: begin
              if (cursor_row != '0) begin
                cursor_row_next = cursor_row - 7'd1;
                op_sel = OP_MOVE;
              end
            end
            ESC_DOWN: begin
              if ({1'b0, cursor_row} + 8'd1 < {1'b0, lines}) begin
                cursor_row_next = cursor_row + 7'd1;
                op_sel = OP_MOVE;
              end
            end
            ESC_RIGHT: begin
              if ({1'b0, cursor_col} + 9'd1 < {1'b0, cols}) begin
                cursor_col_next = cursor_col + 8'd1;
                op_sel = OP_MOVE;
              end
            end
            ESC_LEFT: begin
              if (cursor_col != '0) begin
                cursor_col_next = cursor_col - 8'd1;
                op_sel = OP_MOVE;
              end
            end
            ESC_CLR_HOME: begin
              cursor_row_next = '0;
              cursor_col_next = '0;
              op_sel = OP_CLEAR_HOME;
            end
            ESC_GFX_ON:  flag_bits_next[F_GRAPHICS] = 1'b1;
            ESC_GFX_OFF: flag_bits_next[F_GRAPHICS] = 1'b0;
            ESC_HOME: begin
              if (cursor_row != '0 || cursor_col != '0) begin
                cursor_row_next = '0;
                cursor_col_next = '0;
                op_sel = OP_MOVE;
              end
            end
            ESC_REV_LF: begin
              if (cursor_row != '0) begin
                cursor_row_next = cursor_row - 7'd1;
                op_sel = OP_MOVE;
              end else begin
                op_sel = OP_SCROLL_DOWN;
              end
            end
            ESC_CLR_EOS:   op_sel = OP_CLR_EOS;
            ESC_CLR_EOL:   op_sel = OP_CLR_EOL;
            ESC_INS_LINE:  op_sel = OP_INS_LINE;
            ESC_DEL_LINE:  op_sel = OP_DEL_LINE;
            ESC_INS_BLANK: op_sel = OP_INS_BLANK;
            ESC_DEL_CHAR:  op_sel = OP_DEL_CHAR;
            ESC_SET_BG:    pstate_next = PS_ESCS;
            ESC_SET_FG:    pstate_next = PS_ESCT;
            ESC_ADDR:      pstate_next = PS_ESCY;
            ESC_IDENT: begin
              op_sel   = OP_REPLY;
              char_sel = REPLY_0;
            end
            ESC_HOLD_ON:    flag_bits_next[F_HOLD]    = 1'b1;
            ESC_HOLD_OFF:   flag_bits_next[F_HOLD]    = 1'b0;
            ESC_CUR_HIDE:   flag_bits_next[F_CURHIDE] = 1'b1;
            ESC_CUR_SHOW:   flag_bits_next[F_CURHIDE] = 1'b0;
            ESC_ALTCS_ON:   flag_bits_next[F_ALTCS]   = 1'b1;
            ESC_ALTCS_OFF:  flag_bits_next[F_ALTCS]   = 1'b0;
            ESC_BOLD_ON:    attr_bits_next[ATTR_BOLD]     = 1'b1;
            ESC_BOLD_OFF:   attr_bits_next[ATTR_BOLD]     = 1'b0;
            ESC_UL_ON:      attr_bits_next[ATTR_ULINE]    = 1'b1;
            ESC_UL_OFF:     attr_bits_next[ATTR_ULINE]    = 1'b0;
            ESC_REV_ON:     attr_bits_next[ATTR_INVERSE]  = 1'b1;
            ESC_REV_OFF:    attr_bits_next[ATTR_INVERSE]  = 1'b0;
            ESC_BLINK_ON:   attr_bits_next[ATTR_BLINK]    = 1'b1;
            ESC_BLINK_OFF:  attr_bits_next[ATTR_BLINK]    = 1'b0;
            ESC_ATTR_RST: begin
              attr_bits_next = '0;
              fg_now_next    = default_fg;
              bg_now_next    = default_bg;
            end
            ESC_ALTKEY_ON:  flag_bits_next[F_ALTKEYS]     = 1'b1;
            ESC_ALTKEY_OFF: flag_bits_next[F_ALTKEYS]     = 1'b0;
            ESC_SO_ON:      attr_bits_next[ATTR_STANDOUT] = 1'b1;
            ESC_SO_OFF:     attr_bits_next[ATTR_STANDOUT] = 1'b0;
            default: ;
          endcase
        end
        PS_ESCY: begin
          pstate_next      = PS_ESCYL;
          pending_row_next = c - CH_SPACE;
        end
        PS_ESCYL: begin
          pstate_next = PS_NORMAL;
          if (addr_row != {1'b0, cursor_row} || addr_col != cursor_col) begin
            cursor_row_next = addr_row[ROW_W-1:0];
            cursor_col_next = addr_col;
            op_sel = OP_MOVE;
          end
        end
        PS_ESCS: begin
          pstate_next = PS_NORMAL;
          bg_now_next = pick_color(c, bg_now, default_bg);
        end
        PS_ESCT: begin
          pstate_next = PS_NORMAL;
          fg_now_next = pick_color(c, fg_now, default_fg);
        end
        default: pstate_next = PS_NORMAL;
      endcase
    end

    // Print reports the written cell, everything else the new cursor
    if (op_sel == OP_PRINT) begin
      row_sel = cursor_row;
      col_sel = cursor_col;
    end else begin
      row_sel = cursor_row_next;
      col_sel = cursor_col_next;
    end
  end

  // Effective screen size after a configuration write
  always_comb begin
    cfg_cols  = cols;
    cfg_lines = lines;
    if (cfg_wr_en && cfg_index == CFG_NUM_COLS)  cfg_cols  = eff_cols(cfg_data);
    if (cfg_wr_en && cfg_index == CFG_NUM_LINES) cfg_lines = eff_lines(cfg_data[ROW_W-1:0]);
  end

  // Advance parser state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols    <= RstCols;
      num_lines   <= RstLines;
      default_fg  <= RstFg;
      default_bg  <= RstBg;
      pstate      <= PS_NORMAL;
      pending_row <= '0;
      cursor_row  <= '0;
      cursor_col  <= '0;
      attr_bits   <= '0;
      fg_now      <= RstFg;
      bg_now      <= RstBg;
      flag_bits   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_NUM_COLS:   num_cols   <= cfg_data;
        CFG_NUM_LINES:  num_lines  <= cfg_data[ROW_W-1:0];
        CFG_DEFAULT_FG: default_fg <= cfg_data[COLOR_W-1:0];
        CFG_DEFAULT_BG: default_bg <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
      // Pull the cursor inside a shrunk screen
      if (cursor_col >= cfg_cols)  cursor_col <= cfg_cols - 8'd1;
      if (cursor_row >= cfg_lines) cursor_row <= cfg_lines - 7'd1;
    end else if (in_fire) begin
      pstate      <= pstate_next;
      pending_row <= pending_row_next;
      cursor_row  <= cursor_row_next;
      cursor_col  <= cursor_col_next;
      attr_bits   <= attr_bits_next;
      fg_now      <= fg_now_next;
      bg_now      <= bg_now_next;
      flag_bits   <= flag_bits_next;
    end
  end

  // Output control: load on accept, step through reply bytes, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      reply_left <= 2'd0;
    end else if (in_fire) begin
      out_valid  <= 1'b1;
      reply_left <= (op_sel == OP_REPLY) ? 2'd2 : 2'd0;
    end else if (out_fire) begin
      if (reply_left != 2'd0) begin
        reply_left <= reply_left - 2'd1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmds.op         <= op_sel;
      cmds.char_code  <= char_sel;
      cmds.row        <= row_sel;
      cmds.col        <= col_sel;
      cmds.attributes <= attr_bits_next;
      cmds.fg_color   <= fg_now_next;
      cmds.bg_color   <= bg_now_next;
      cmds.mode_flags <= flag_bits_next;
      cmds.last       <= (op_sel != OP_REPLY);
    end else if (out_fire && reply_left != 2'd0) begin
      cmds.char_code <= (reply_left == 2'd2) ? REPLY_1 : REPLY_2;
      cmds.last      <= (reply_left == 2'd1);
    end
  end

  assign cmds.valid = out_valid;

endmodule

// ===== rtl/vt52_chk.sv =====
// Port-level assertions for the VT52 escape parser, bound into the parser module.
module vt52_chk import vt52_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [OP_W-1:0]   out_op,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last
);

  // Reset leaves no command pending
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("command valid after reset");

  // Only print and reply carry a character
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_op != OP_PRINT && out_op != OP_REPLY |-> out_char == '0)
    else $error("character code on a non-character command");

  // Input waits while a reply sequence is still open
  a_reply_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_op == OP_REPLY && !out_last |-> !in_ready)
    else $error("byte accepted in the middle of a reply");

  // A taken non-final reply byte is followed by another reply byte
  a_reply_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_op == OP_REPLY && !out_last
      |=> out_valid && out_op == OP_REPLY)
    else $error("reply sequence broken");

  // A stalled command holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_op) && $stable(out_char))
    else $error("stalled command changed");

endmodule

bind vt52_escape_parser vt52_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (chars.ready),
  .out_valid (cmds.valid),
  .out_ready (cmds.ready),
  .out_op    (cmds.op),
  .out_char  (cmds.char_code),
  .out_last  (cmds.last)
);
